@@ hdl/spq_pkg.sv @@
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ID_BITS   = 8;
  localparam int KEY_BITS  = 16;
  localparam int CNT_BITS  = $clog2(DEPTH_DEF + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [ID_BITS-1:0]  thread_id;
    logic [KEY_BITS-1:0] priority_key;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                found;
    logic [CNT_BITS-1:0] entry_count;
    logic                head_valid;
    logic [ID_BITS-1:0]  head_id;
    logic [KEY_BITS-1:0] head_key;
  } out_word_t;

  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

@@ hdl/spq_cell.sv @@
module spq_cell (
  input  logic                         clk,
  input  spq_pkg::cell_ctrl_t          ctrl,
  input  logic                         slot_valid,
  input  logic [spq_pkg::ID_BITS-1:0]  req_id,
  input  logic [spq_pkg::KEY_BITS-1:0] req_key,
  input  logic                         gt_left,
  input  logic                         shift_in,
  input  logic [spq_pkg::ID_BITS-1:0]  left_id,
  input  logic [spq_pkg::KEY_BITS-1:0] left_key,
  input  logic [spq_pkg::ID_BITS-1:0]  right_id,
  input  logic [spq_pkg::KEY_BITS-1:0] right_key,
  output logic [spq_pkg::ID_BITS-1:0]  id_r,
  output logic [spq_pkg::KEY_BITS-1:0] key_r,
  output logic [spq_pkg::ID_BITS-1:0]  id_nxt,
  output logic [spq_pkg::KEY_BITS-1:0] key_nxt,
  output logic                         gt_r,
  output logic                         match_r
);

  // insert: new word at boundary, shift right; remove: shift left
  always_comb begin
    id_nxt  = id_r;
    key_nxt = key_r;
    if (ctrl.ins) begin
      if (gt_left) begin
        id_nxt  = left_id;
        key_nxt = left_key;
      end else if (gt_r) begin
        id_nxt  = req_id;
        key_nxt = req_key;
      end
    end else if (ctrl.rem && shift_in) begin
      id_nxt  = right_id;
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      gt_r    <= !slot_valid || (key_r > req_key);
      match_r <= slot_valid && (id_r == req_id);
    end
    if (ctrl.upd_en) begin
      id_r  <= id_nxt;
      key_r <= key_nxt;
    end
  end

endmodule

@@ hdl/sorted_priority_queue_remove_by_id_unit.sv @@
// Sorted priority queue with remove by id, built as a chain of slot cells.
// A word is captured, compared in the cells, then written back in the update state, which waits on out_stall.
// A new word is taken only in idle, once capture, compare and update of the last one are through.
// A held result does not block the next input; the update waits until it is taken.
// Reset (rst_n, synchronous, active low) empties the queue; slot contents stay unset.
module sorted_priority_queue_remove_by_id_unit #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_word_t out_word
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LVLS  = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t                       state_r, state_nxt;
  logic [1:0]                   cmd_r;
  logic [spq_pkg::ID_BITS-1:0]  id_r;
  logic [spq_pkg::KEY_BITS-1:0] key_r;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic                         out_valid_r;
  spq_pkg::out_word_t           out_word_r;

  spq_pkg::cell_ctrl_t          ctrl;
  logic                         upd_go;
  logic                         is_ins, is_rem, is_find, full, found;
  logic [1:0]                   status;

  logic [spq_pkg::ID_BITS-1:0]  c_id   [DEPTH];
  logic [spq_pkg::KEY_BITS-1:0] c_key  [DEPTH];
  logic [spq_pkg::ID_BITS-1:0]  c_idn  [DEPTH];
  logic [spq_pkg::KEY_BITS-1:0] c_keyn [DEPTH];
  logic [DEPTH-1:0]             c_gt, c_match;
  logic [DEPTH-1:0]             pre [LVLS+1];

  assign is_ins  = (cmd_r == spq_pkg::CMD_INSERT);
  assign is_rem  = (cmd_r == spq_pkg::CMD_REMOVE);
  assign is_find = (cmd_r == spq_pkg::CMD_FIND);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign upd_go  = (state_r == S_UPD) && (!out_valid_r || !out_stall);

  // prefix OR of match flags: slot i shifts left when a match sits at or before it
  assign pre[0] = c_match;
  for (genvar l = 0; l < LVLS; l++) begin : g_lvl
    for (genvar i = 0; i < DEPTH; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_or
        assign pre[l+1][i] = pre[l][i] | pre[l][i-(1<<l)];
      end else begin : g_pass
        assign pre[l+1][i] = pre[l][i];
      end
    end
  end
  assign found = pre[LVLS][DEPTH-1];

  always_comb begin
    ctrl.cmp_en = (state_r == S_CMP);
    ctrl.upd_en = upd_go;
    ctrl.ins    = is_ins && !full;
    ctrl.rem    = is_rem;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .slot_valid (count_r > CNT_W'(i)),
      .req_id     (id_r),
      .req_key    (key_r),
      .gt_left    ((i == 0) ? 1'b0 : c_gt[(i == 0) ? 0 : i-1]),
      .shift_in   (pre[LVLS][i]),
      .left_id    (c_id[(i == 0) ? 0 : i-1]),
      .left_key   (c_key[(i == 0) ? 0 : i-1]),
      .right_id   (c_id[(i == DEPTH-1) ? i : i+1]),
      .right_key  (c_key[(i == DEPTH-1) ? i : i+1]),
      .id_r       (c_id[i]),
      .key_r      (c_key[i]),
      .id_nxt     (c_idn[i]),
      .key_nxt    (c_keyn[i]),
      .gt_r       (c_gt[i]),
      .match_r    (c_match[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    status    = spq_pkg::ST_DONE;
    if (is_ins) begin
      if (full) status = spq_pkg::ST_FULL;
      else count_nxt = count_r + CNT_W'(1);
    end else if (is_rem) begin
      if (found) count_nxt = count_r - CNT_W'(1);
      else status = spq_pkg::ST_MISSING;
    end else if (is_find && !found) begin
      status = spq_pkg::ST_MISSING;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   if (upd_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_word.cmd;
      id_r  <= in_word.thread_id;
      key_r <= in_word.priority_key;
    end
    if (upd_go) begin
      out_word_r.status      <= status;
      out_word_r.found       <= (is_rem || is_find) && found;
      out_word_r.entry_count <= spq_pkg::CNT_BITS'(count_nxt);
      out_word_r.head_valid  <= (count_nxt != '0);
      out_word_r.head_id     <= (count_nxt != '0) ? c_idn[0] : '0;
      out_word_r.head_key    <= (count_nxt != '0) ? c_keyn[0] : '0;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
